// ===== rtl/core/vpa_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the variable partition allocator
// no dependencies

package vpa_pkg;

   localparam int SlotCount = 64;
   localparam int SlotIdxW  = $clog2(SlotCount);
   localparam int CountW    = $clog2(SlotCount + 1);
   localparam int SizeW     = 16;
   localparam int IdW       = 8;
   localparam int PidW      = 7;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LIST   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_ADDED      = 3'd0,
      STATUS_NO_MEMORY  = 3'd1,
      STATUS_TABLE_FULL = 3'd2,
      STATUS_REMOVED    = 3'd3,
      STATUS_NOT_FOUND  = 3'd4,
      STATUS_LIST_ENTRY = 3'd5,
      STATUS_LIST_EMPTY = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_LIST,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/core/vpa_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module vpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/variable_partition_allocator.sv =====
`timescale 1ns / 1ps
// variable partition allocator top level: slot table, free counter, command sequencer
// depends on vpa_pkg and vpa_ram

// Commands are taken when start is high and busy is low; each result shows on the rsp_
// ports for one cycle with rsp_valid high, registered in the cycle after the work that
// makes it. An add is done in idle. A remove of a live slot passes through the remove
// state, which adds back the size read from the slot size ram; a remove of an unknown id
// is done in idle. A list with no live slot is done in idle; otherwise the scan runs up to
// the last live slot, then the drain state follows: the scan reads one slot of the size
// ram per cycle. Results cannot be held off, so the receiver must take one every cycle that
// rsp_valid is high. Writing csr_wr_data loads the free memory and empties the table; the
// user must write it only while the block is idle, as the block does not enforce this.

module variable_partition_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_func,
   input  logic [vpa_pkg::SizeW-1:0]  req_request_size,
   input  logic [vpa_pkg::IdW-1:0]    req_target_id,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic [vpa_pkg::PidW-1:0]   rsp_process_id,
   output logic [vpa_pkg::SizeW-1:0]  rsp_entry_size,
   output logic [vpa_pkg::SizeW-1:0]  rsp_free_memory,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [vpa_pkg::SizeW-1:0]  csr_wr_data
);

   import vpa_pkg::*;

   state_type state_ff, state_in;

   logic [CountW-1:0]    used_ff, used_in;
   logic [SizeW-1:0]     remaining_ff, remaining_in;
   logic [SlotCount-1:0] valid_ff, valid_in;
   logic [SlotCount-1:0] live_ff, live_in;
   logic [SlotIdxW-1:0]  scan_ff, scan_in;
   logic [PidW-1:0]      rm_id_ff, rm_id_in;

   logic                 hit_ff, hit_in;
   logic                 hit_last_ff, hit_last_in;
   logic [PidW-1:0]      hit_id_ff, hit_id_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [PidW-1:0]      rsp_pid_ff, rsp_pid_in;
   logic [SizeW-1:0]     rsp_size_ff, rsp_size_in;
   logic [SizeW-1:0]     rsp_free_ff;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we;
   logic [SlotIdxW-1:0]  ram_waddr;
   logic [SlotIdxW-1:0]  ram_raddr;
   logic [SizeW-1:0]     ram_rdata;

   logic                 accept;
   logic [IdW-1:0]       tid_m1;
   logic                 rm_ok;
   logic [SlotCount-1:0] live_now;
   logic [SlotCount-1:0] live_hi;
   logic                 scan_hit;
   logic                 scan_last;
   logic [SizeW:0]       rm_sum;
   logic [PidW-1:0]      rm_idx_w;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign tid_m1 = req_target_id - IdW'(1);
   assign rm_ok  = (req_target_id != '0)
                && (req_target_id <= IdW'(used_ff))
                && valid_ff[tid_m1[SlotIdxW-1:0]];

   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         live_now[i] = valid_ff[i] && (CountW'(i) < used_ff);
      end
   end

   // a live slot is the last one when nothing live sits above it
   assign live_hi   = live_ff >> scan_ff;
   assign scan_hit  = live_ff[scan_ff];
   assign scan_last = ((live_hi >> 1) == '0);

   assign rm_sum   = {1'b0, remaining_ff} + {1'b0, ram_rdata};
   assign rm_idx_w = rm_id_ff - PidW'(1);

   vpa_ram #(
      .WIDTH (SizeW),
      .DEPTH (SlotCount)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_request_size),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_REMOVE: state_in = rm_ok ? ST_REMOVE : ST_IDLE;
                  FUNC_LIST:   state_in = (live_now != '0) ? ST_LIST : ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_REMOVE: state_in = ST_IDLE;
         ST_LIST: begin
            if (scan_hit && scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ram_we        = 1'b0;
      ram_waddr     = used_ff[SlotIdxW-1:0];
      ram_raddr     = scan_ff;
      used_in       = used_ff;
      remaining_in  = remaining_ff;
      valid_in      = valid_ff;
      live_in       = live_ff;
      scan_in       = scan_ff;
      rm_id_in      = rm_id_ff;
      hit_in        = 1'b0;
      hit_last_in   = hit_last_ff;
      hit_id_in     = hit_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_ADDED;
      rsp_pid_in    = '0;
      rsp_size_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_func))
                  FUNC_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_size_in  = req_request_size;
                     priority if (req_request_size > remaining_ff) begin
                        rsp_status_in = STATUS_NO_MEMORY;
                     end else if (used_ff >= CountW'(SlotCount)) begin
                        rsp_status_in = STATUS_TABLE_FULL;
                     end else begin
                        ram_we                            = 1'b1;
                        valid_in[used_ff[SlotIdxW-1:0]]   = 1'b1;
                        used_in                           = used_ff + CountW'(1);
                        remaining_in  = remaining_ff - req_request_size;
                        rsp_status_in = STATUS_ADDED;
                        rsp_pid_in    = PidW'(used_ff) + PidW'(1);
                     end
                  end
                  FUNC_REMOVE: begin
                     ram_raddr = tid_m1[SlotIdxW-1:0];
                     rm_id_in  = req_target_id[PidW-1:0];
                     if (!rm_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  FUNC_LIST: begin
                     live_in = live_now;
                     scan_in = '0;
                     if (live_now == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_LIST_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REMOVE: begin
            remaining_in = rm_sum[SizeW] ? '1 : rm_sum[SizeW-1:0];
            valid_in[rm_idx_w[SlotIdxW-1:0]] = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_REMOVED;
            rsp_pid_in    = rm_id_ff;
            rsp_size_in   = ram_rdata;
         end
         ST_LIST: begin
            hit_in      = scan_hit;
            hit_last_in = scan_last;
            hit_id_in   = PidW'(scan_ff) + PidW'(1);
            scan_in     = scan_ff + SlotIdxW'(1);
         end
         ST_DRAIN: begin
         end
         default: begin
         end
      endcase

      // size of a listed slot arrives from the ram in the cycle after its scan
      if (hit_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_LIST_ENTRY;
         rsp_pid_in    = hit_id_ff;
         rsp_size_in   = ram_rdata;
         rsp_last_in   = hit_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         remaining_ff <= '0;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            used_ff      <= '0;
            remaining_ff <= csr_wr_data;
            valid_ff     <= '0;
         end else begin
            used_ff      <= used_in;
            remaining_ff <= remaining_in;
            valid_ff     <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      live_ff       <= live_in;
      scan_ff       <= scan_in;
      rm_id_ff      <= rm_id_in;
      hit_last_ff   <= hit_last_in;
      hit_id_ff     <= hit_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_free_ff   <= remaining_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_process_id  = rsp_pid_ff;
   assign rsp_entry_size  = rsp_size_ff;
   assign rsp_free_memory = rsp_free_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/core/vpa_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the variable partition allocator, bound to the top level
// depends on vpa_pkg and variable_partition_allocator

module vpa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [2:0]                rsp_status,
   input logic [vpa_pkg::PidW-1:0]  rsp_process_id,
   input logic [vpa_pkg::SizeW-1:0] rsp_entry_size,
   input logic                      rsp_last
);

   import vpa_pkg::*;

   // a result only follows an accepted item or ongoing work
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without a pending item");

   // more results of a list are still to come, so the block stays busy
   a_busy_mid_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (busy && rsp_status == STATUS_LIST_ENTRY))
      else $error("non-final result outside a list walk");

   a_added_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ADDED) |-> (rsp_process_id != '0 && rsp_last))
      else $error("granted add without an id");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NOT_FOUND)
         |-> (rsp_process_id == '0 && rsp_entry_size == '0 && rsp_last))
      else $error("failed remove reports an entry");

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_process_id (rsp_process_id),
   .rsp_entry_size (rsp_entry_size),
   .rsp_last       (rsp_last)
);

// ===== sim/variable_partition_allocator_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the variable partition allocator: directed and random commands
// depends on vpa_pkg and the variable_partition_allocator rtl

module variable_partition_allocator_tb;
   import vpa_pkg::*;

   localparam int CycleLimit = 300000;

   typedef struct packed {
      status_type         status;
      logic [PidW-1:0]    pid;
      logic [SizeW-1:0]   size;
      logic [SizeW-1:0]   free_kb;
      logic               last;
   } alloc_reply_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic [SizeW-1:0]   req_request_size;
   logic [IdW-1:0]     req_target_id;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [PidW-1:0]    rsp_process_id;
   logic [SizeW-1:0]   rsp_entry_size;
   logic [SizeW-1:0]   rsp_free_memory;
   logic               rsp_last;
   logic               csr_wr_en;
   logic [SizeW-1:0]   csr_wr_data;

   // allocator state as predicted from the accepted items
   logic [SizeW-1:0]   part_size [SlotCount];
   logic               part_live [SlotCount];
   int                 parts_used;
   logic [SizeW-1:0]   free_kb;
   alloc_reply_type    allocator_replies[$];

   int                 failures;
   int                 cycle_count;
   int                 idle_pct;

   variable_partition_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_request_size (req_request_size),
      .req_target_id    (req_target_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_process_id   (rsp_process_id),
      .rsp_entry_size   (rsp_entry_size),
      .rsp_free_memory  (rsp_free_memory),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("[variable_partition_allocator] ERROR");
         $finish;
      end
   end

   function automatic void push_reply(status_type st, int pid, logic [SizeW-1:0] sz,
                                      logic last);
      alloc_reply_type r;
      r.status  = st;
      r.pid     = pid[PidW-1:0];
      r.size    = sz;
      r.free_kb = free_kb;
      r.last    = last;
      allocator_replies.push_back(r);
   endfunction

   function automatic void clear_partitions(logic [SizeW-1:0] total_kb);
      for (int i = 0; i < SlotCount; i++) begin
         part_size[i] = '0;
         part_live[i] = 1'b0;
      end
      parts_used = 0;
      free_kb    = total_kb;
   endfunction

   // predicts the results of one accepted command and updates the partition table
   function automatic void allocate(func_type f, logic [SizeW-1:0] sz, logic [IdW-1:0] tid);
      logic [SizeW:0] sum;
      int             final_idx;
      case (f)
         FUNC_ADD: begin
            if (sz > free_kb) begin
               push_reply(STATUS_NO_MEMORY, 0, sz, 1'b1);
            end else if (parts_used >= SlotCount) begin
               push_reply(STATUS_TABLE_FULL, 0, sz, 1'b1);
            end else begin
               part_size[parts_used] = sz;
               part_live[parts_used] = 1'b1;
               free_kb = free_kb - sz;
               parts_used++;
               push_reply(STATUS_ADDED, parts_used, sz, 1'b1);
            end
         end
         FUNC_REMOVE: begin
            if (tid >= 1 && tid <= parts_used && part_live[tid - 1]) begin
               sum = {1'b0, free_kb} + {1'b0, part_size[tid - 1]};
               part_live[tid - 1] = 1'b0;
               free_kb = sum[SizeW] ? '1 : sum[SizeW-1:0];
               push_reply(STATUS_REMOVED, int'(tid), part_size[tid - 1], 1'b1);
            end else begin
               push_reply(STATUS_NOT_FOUND, 0, '0, 1'b1);
            end
         end
         FUNC_LIST: begin
            final_idx = -1;
            for (int i = 0; i < parts_used; i++)
               if (part_live[i]) final_idx = i;
            if (final_idx < 0) begin
               push_reply(STATUS_LIST_EMPTY, 0, '0, 1'b1);
            end else begin
               for (int i = 0; i <= final_idx; i++)
                  if (part_live[i]) push_reply(STATUS_LIST_ENTRY, i + 1, part_size[i],
                                               i == final_idx);
            end
         end
         default: ;
      endcase
   endfunction

   // issues one command; returns at the edge that takes it, with start still high
   task automatic send_item(func_type f, logic [SizeW-1:0] sz, logic [IdW-1:0] tid);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_request_size <= sz;
      req_target_id    <= tid;
      do @(posedge clock); while (busy !== 1'b0);
      allocate(f, sz, tid);
   endtask

   // loads total memory once every pending result is out and the block has settled
   task automatic load_total(logic [SizeW-1:0] total_kb);
      start <= 1'b0;
      while (allocator_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= total_kb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clear_partitions(total_kb);
   endtask

   task automatic check_field(string name, logic [SizeW-1:0] want, logic [SizeW-1:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      alloc_reply_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (allocator_replies.size() == 0) begin
            failures++;
            $display("%0t unexpected result: expected none, actual status %0d id %0d",
                     $time, rsp_status, rsp_process_id);
         end else begin
            want = allocator_replies.pop_front();
            check_field("status", SizeW'(want.status), SizeW'(rsp_status));
            check_field("process_id", SizeW'(want.pid), SizeW'(rsp_process_id));
            check_field("entry_size", want.size, rsp_entry_size);
            check_field("free_memory", want.free_kb, rsp_free_memory);
            check_field("last", SizeW'(want.last), SizeW'(rsp_last));
         end
      end
   end

   // table after reset holds no memory: only zero sized adds fit
   task automatic test_after_reset();
      send_item(FUNC_LIST, '0, '0);
      send_item(FUNC_ADD, '0, '0);
      send_item(FUNC_ADD, 16'd1, '0);
      send_item(FUNC_LIST, '0, '0);
      send_item(FUNC_REMOVE, '0, 8'd0);
      send_item(FUNC_REMOVE, '0, 8'd1);
      send_item(FUNC_REMOVE, '0, 8'd1);
      send_item(FUNC_NONE, 16'hffff, 8'hff);
      send_item(FUNC_LIST, '0, '0);
   endtask

   task automatic test_memory_limits();
      load_total(16'hffff);
      send_item(FUNC_ADD, 16'hffff, 8'h00);
      send_item(FUNC_ADD, 16'd1, 8'h00);
      send_item(FUNC_ADD, 16'd0, 8'h00);
      send_item(FUNC_REMOVE, '0, 8'd3);
      send_item(FUNC_REMOVE, '0, 8'hff);
      send_item(FUNC_LIST, '0, '0);
      send_item(FUNC_REMOVE, '0, 8'd1);
      send_item(FUNC_ADD, 16'h5555, 8'haa);
      send_item(FUNC_ADD, 16'haaaa, 8'h55);
      send_item(FUNC_ADD, 16'h0001, 8'h00);
      send_item(FUNC_NONE, 16'h0000, 8'h00);
      send_item(FUNC_LIST, '0, '0);
      load_total(16'h0000);
      send_item(FUNC_ADD, 16'd1, '0);
      send_item(FUNC_LIST, '0, '0);
   endtask

   task automatic test_table_full();
      load_total(16'd4000);
      for (int i = 0; i < SlotCount; i++)
         send_item(FUNC_ADD, 16'($urandom_range(0, 40)), '0);
      send_item(FUNC_ADD, 16'd1, '0);
      send_item(FUNC_ADD, 16'hffff, '0);
      send_item(FUNC_LIST, '0, '0);
      send_item(FUNC_REMOVE, '0, 8'd64);
      send_item(FUNC_REMOVE, '0, 8'd64);
      send_item(FUNC_REMOVE, '0, 8'd65);
      send_item(FUNC_ADD, 16'd0, '0);
      send_item(FUNC_REMOVE, '0, 8'd1);
      send_item(FUNC_LIST, '0, '0);
   endtask

   // mostly valid adds and removes against the live table, with lists and some noise
   task automatic test_random_traffic(int count, logic [SizeW-1:0] first_total,
                                      logic [SizeW-1:0] second_total);
      func_type         f;
      logic [SizeW-1:0] sz;
      logic [IdW-1:0]   tid;
      load_total(first_total);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) load_total(second_total);
         sz  = 16'($urandom);
         tid = 8'($urandom);
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: f = FUNC_ADD;
            8, 9, 10, 11, 12, 13:   f = FUNC_REMOVE;
            14, 15, 16, 17, 18:     f = FUNC_LIST;
            default:                f = FUNC_NONE;
         endcase
         if (f == FUNC_ADD) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: sz = 16'($urandom_range(0, free_kb >> 2));
               6, 7:             sz = 16'($urandom_range(0, free_kb));
               8:                sz = (free_kb == 16'hffff) ? free_kb : free_kb + 16'd1;
               default: ;
            endcase
         end else if (f == FUNC_REMOVE && $urandom_range(9) < 8) begin
            tid = 8'($urandom_range(0, parts_used + 1));
         end
         send_item(f, sz, tid);
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_func         = FUNC_ADD;
      req_request_size = '0;
      req_target_id    = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      failures         = 0;
      cycle_count      = 0;
      idle_pct         = 31;
      clear_partitions('0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_memory_limits();
      test_table_full();
      test_random_traffic(60, 16'($urandom_range(1000, 8000)), 16'hffff);
      idle_pct = 55;
      test_random_traffic(60, 16'($urandom), 16'($urandom_range(16, 300)));
      idle_pct = 0;
      test_random_traffic(60, 16'hffff, 16'($urandom));

      start <= 1'b0;
      while (allocator_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("[variable_partition_allocator] OK");
      end else begin
         $display("[variable_partition_allocator] ERROR");
      end
      $finish;
   end

endmodule
